FILE: sv/omni_wheel_kinematics_pwm_top_defines.svh
// assertion macros shared by the checker of the omni wheel kinematics block
// each macro expects a signal named clk, and the two masked ones one named rst, in the scope where it is used
`ifndef OMNI_WHEEL_KINEMATICS_PWM_TOP_DEFINES_SVH
`define OMNI_WHEEL_KINEMATICS_PWM_TOP_DEFINES_SVH

// same-cycle implication, masked while in reset
`define OWK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define OWK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define OWK_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/owk_pkg.sv
// shared widths, types and constants of the omni wheel kinematics pipeline
// no dependencies; used by every design module of the block
`default_nettype none

package owk_pkg;

  localparam int SPEED_W = 34;   // signed wheel speed in 2^-29 units
  localparam int MAG_W   = 33;   // speed magnitude
  localparam int DVD_W   = 40;   // magnitude times one hundred
  localparam int PCT_W   = 7;
  localparam int DUTY_W  = 11;
  localparam int WHEELS  = 3;

  localparam int DIV_STEPS    = PCT_W;
  localparam int SPEED_STAGES = 3;
  localparam int PIPE_DEPTH   = SPEED_STAGES + 1 + DIV_STEPS + 1;

  localparam int PERCENT   = 100;
  localparam int DUTY_FULL = 1024;
  localparam int PCT_CNT   = 1 << PCT_W;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [DVD_W-1:0]          dvd_t;
  typedef logic [PCT_W-1:0]          pct_t;
  typedef logic [DUTY_W-1:0]         duty_t;
  typedef duty_t [PCT_CNT-1:0]       duty_lut_t;

  // 2/sqrt(3) in 2^-16 units
  localparam logic signed [17:0] INV_SIN60 = 18'sd75674;
  localparam mag_t ONE_Q29 = mag_t'(1) << 29;

  // divider state carried from stage to stage
  typedef struct packed {
    logic [WHEELS-1:0]  dir;
    mag_t               norm;
    dvd_t [WHEELS-1:0]  rem;
    pct_t [WHEELS-1:0]  quo;
  } div_bus_t;

  // percent to pwm duty, masked to the field width
  function automatic duty_lut_t build_duty_lut();
    duty_lut_t lut;
    int        prod;
    for (int i = 0; i < PCT_CNT; i++) begin
      prod   = (i * DUTY_FULL) / PERCENT;
      lut[i] = prod[DUTY_W-1:0];
    end
    return lut;
  endfunction

  localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

`default_nettype wire

FILE: sv/omni_wheel_kinematics_pwm_top.sv
// top level of the omni wheel kinematics and pwm duty pipeline
// depends on owk_pkg, owk_speed, owk_norm and owk_div_stage
//
//   channel  handshake             payload
//   input    in_valid / in_ready   vel_x, vel_y, vel_rot
//   output   out_valid / out_ready dir_wheel0..2, duty_wheel0..2
//
// twelve register stages: three for speeds, one to pick the divisor, seven
// divider stages that each settle one quotient bit, one for the duty table.
// one transaction per cycle, unless out_ready stalls a full pipeline.
// reset clears the stage valid bits only.
// a full stage holds while the one after it cannot load, so bubbles close up on a stall.
`default_nettype none

module omni_wheel_kinematics_pwm_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [15:0]     vel_x,
  input  wire logic signed [15:0]     vel_y,
  input  wire logic signed [15:0]     vel_rot,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        dir_wheel0,
  output logic [10:0]                 duty_wheel0,
  output logic                        dir_wheel1,
  output logic [10:0]                 duty_wheel1,
  output logic                        dir_wheel2,
  output logic [10:0]                 duty_wheel2
);

  localparam int LAST    = owk_pkg::PIPE_DEPTH - 1;
  localparam int NORM_ST = owk_pkg::SPEED_STAGES;

  logic [owk_pkg::PIPE_DEPTH-1:0] vld;
  logic [owk_pkg::PIPE_DEPTH-1:0] en;

  owk_pkg::mag_t [owk_pkg::WHEELS-1:0] mag;
  logic [owk_pkg::WHEELS-1:0]          dir;
  owk_pkg::div_bus_t                   bus [owk_pkg::DIV_STEPS+1];

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[LAST] = ~vld[LAST] | out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < owk_pkg::PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[LAST];

  owk_speed u_speed (
    .clk     (clk),
    .en      (en[owk_pkg::SPEED_STAGES-1:0]),
    .vel_x   (vel_x),
    .vel_y   (vel_y),
    .vel_rot (vel_rot),
    .mag     (mag),
    .dir     (dir)
  );

  owk_norm u_norm (
    .clk (clk),
    .en  (en[NORM_ST]),
    .mag (mag),
    .dir (dir),
    .bus (bus[0])
  );

  // most significant quotient bit first
  for (genvar g = 0; g < owk_pkg::DIV_STEPS; g++) begin : g_div
    owk_div_stage u_div (
      .clk     (clk),
      .en      (en[NORM_ST+1+g]),
      .bit_pos (3'(owk_pkg::DIV_STEPS - 1 - g)),
      .bus_in  (bus[g]),
      .bus_out (bus[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      dir_wheel0  <= bus[owk_pkg::DIV_STEPS].dir[0];
      dir_wheel1  <= bus[owk_pkg::DIV_STEPS].dir[1];
      dir_wheel2  <= bus[owk_pkg::DIV_STEPS].dir[2];
      duty_wheel0 <= owk_pkg::DUTY_LUT[bus[owk_pkg::DIV_STEPS].quo[0]];
      duty_wheel1 <= owk_pkg::DUTY_LUT[bus[owk_pkg::DIV_STEPS].quo[1]];
      duty_wheel2 <= owk_pkg::DUTY_LUT[bus[owk_pkg::DIV_STEPS].quo[2]];
    end
  end

endmodule

`default_nettype wire

FILE: sv/owk_speed.sv
// first three pipeline stages: scaled inputs, wheel speeds, magnitudes and directions
// depends on owk_pkg
`default_nettype none

module owk_speed (
  input  wire logic                                 clk,
  input  wire logic [owk_pkg::SPEED_STAGES-1:0]     en,
  input  wire logic signed [15:0]                   vel_x,
  input  wire logic signed [15:0]                   vel_y,
  input  wire logic signed [15:0]                   vel_rot,
  output owk_pkg::mag_t [owk_pkg::WHEELS-1:0]       mag,
  output logic [owk_pkg::WHEELS-1:0]                dir
);

  owk_pkg::speed_t xs;
  logic signed [15:0] y1;
  logic signed [15:0] w1;
  owk_pkg::speed_t [owk_pkg::WHEELS-1:0] spd;

  owk_pkg::speed_t yh;
  owk_pkg::speed_t yf;
  owk_pkg::speed_t wf;
  owk_pkg::speed_t [owk_pkg::WHEELS-1:0] neg;

  // stage one: x over sin60 is the only real product
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xs <= vel_x * owk_pkg::INV_SIN60;
      y1 <= vel_y;
      w1 <= vel_rot;
    end
  end

  assign yh = {{3{y1[15]}}, y1, 15'b0};
  assign yf = {{2{y1[15]}}, y1, 16'b0};
  assign wf = {{2{w1[15]}}, w1, 16'b0};

  // stage two: wheel speeds
  always_ff @(posedge clk) begin
    if (en[1]) begin
      spd[0] <= -xs - yh - wf;
      spd[1] <= yf - wf;
      spd[2] <= xs - yh - wf;
    end
  end

  always_comb begin
    for (int i = 0; i < owk_pkg::WHEELS; i++) begin
      neg[i] = -spd[i];
    end
  end

  // stage three: magnitudes fit in one bit less than the signed speed
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < owk_pkg::WHEELS; i++) begin
        dir[i] <= ~spd[i][owk_pkg::SPEED_W-1];
        mag[i] <= spd[i][owk_pkg::SPEED_W-1] ? neg[i][owk_pkg::MAG_W-1:0]
                                               : spd[i][owk_pkg::MAG_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/owk_norm.sv
// normalization stage: largest magnitude, divisor choice and dividend setup
// depends on owk_pkg
`default_nettype none

module owk_norm (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire owk_pkg::mag_t [owk_pkg::WHEELS-1:0] mag,
  input  wire logic [owk_pkg::WHEELS-1:0]          dir,
  output owk_pkg::div_bus_t                        bus
);

  owk_pkg::mag_t top01;
  owk_pkg::mag_t top;
  owk_pkg::dvd_t [owk_pkg::WHEELS-1:0] dvd;

  assign top01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
  assign top   = (mag[2] > top01) ? mag[2] : top01;

  // times one hundred as 64 + 32 + 4
  always_comb begin
    for (int i = 0; i < owk_pkg::WHEELS; i++) begin
      dvd[i] = (owk_pkg::dvd_t'(mag[i]) << 6) + (owk_pkg::dvd_t'(mag[i]) << 5)
             + (owk_pkg::dvd_t'(mag[i]) << 2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bus.dir  <= dir;
      bus.norm <= (top > owk_pkg::ONE_Q29) ? top : owk_pkg::ONE_Q29;
      bus.rem  <= dvd;
      bus.quo  <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/owk_div_stage.sv
// one restoring division step for all three wheels, one quotient bit per stage
// depends on owk_pkg
`default_nettype none

module owk_div_stage (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [2:0]             bit_pos,
  input  wire owk_pkg::div_bus_t      bus_in,
  output owk_pkg::div_bus_t           bus_out
);

  owk_pkg::dvd_t shifted;
  owk_pkg::div_bus_t bus_next;

  assign shifted = owk_pkg::dvd_t'(bus_in.norm) << bit_pos;

  always_comb begin
    bus_next = bus_in;
    for (int i = 0; i < owk_pkg::WHEELS; i++) begin
      if (bus_in.rem[i] >= shifted) begin
        bus_next.rem[i]          = bus_in.rem[i] - shifted;
        bus_next.quo[i][bit_pos] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bus_out <= bus_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/owk_checker.sv
// port-level checks of the omni wheel kinematics block and its bind
// depends on omni_wheel_kinematics_pwm_top_defines.svh
`default_nettype none
`include "omni_wheel_kinematics_pwm_top_defines.svh"

module owk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] duty_wheel0,
  input wire logic [10:0] duty_wheel1,
  input wire logic [10:0] duty_wheel2
);

  `OWK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `OWK_ASSERT_NEXT(a_duty_hold, out_valid && !out_ready,
                   $stable(duty_wheel0) && $stable(duty_wheel1) && $stable(duty_wheel2),
                   "duty changed while stalled")
  // a free output stage leaves room all the way to the input
  `OWK_ASSERT_NOW(a_room, !out_valid || out_ready, in_ready, "input blocked with free pipeline")
  `OWK_ASSERT_RST(a_rst_clear, rst, !out_valid, "result shown right after reset")

endmodule

bind omni_wheel_kinematics_pwm_top owk_checker u_owk_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .duty_wheel0 (duty_wheel0),
  .duty_wheel1 (duty_wheel1),
  .duty_wheel2 (duty_wheel2)
);

`default_nettype wire
